FILE: hw/rtl/kbsv_pkg.sv
// shared types, constants and helper functions for the keyboard synth voice
package kbsv_pkg;

  localparam int unsigned NumKeysDefault = 12;
  localparam int unsigned NoteW          = 4;
  localparam int unsigned OctW           = 4;
  localparam int unsigned VolW           = 4;
  localparam int unsigned PhaseW         = 32;

  localparam logic [1:0] KIND_SCAN   = 2'd0;
  localparam logic [1:0] KIND_NOTE   = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic OUT_EVENT  = 1'b0;
  localparam logic OUT_SAMPLE = 1'b1;

  localparam logic [7:0] RX_PRESSED  = 8'h50;
  localparam logic [7:0] RX_RELEASED = 8'h52;

  localparam logic [VolW-1:0] VOL_MAX     = 4'd8;
  localparam logic [OctW-1:0] OCTAVE_BASE = 4'd4;
  localparam logic [NoteW-1:0] NOTE_COUNT = 4'd12;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] key_bits;
    logic [7:0]  rx_type;
    logic [3:0]  rx_octave;
    logic [7:0]  rx_note;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic        event_pressed;
    logic [3:0]  event_octave;
    logic [3:0]  event_note;
    logic        last;
    logic [7:0]  sample;
    logic [3:0]  volume;
  } out_item_t;

  typedef struct packed {
    logic note_we;
    logic tick;
  } tone_ctrl_t;

  typedef enum logic [1:0] {
    KNOB_HOLD,
    KNOB_UP,
    KNOB_DOWN
  } knob_dir_e;

  // quadrature transition {prev, cur} to direction
  function automatic knob_dir_e knob_dir(input logic [3:0] trans);
    knob_dir_e dir;
    case (trans) inside
      4'b0001, 4'b0111, 4'b1110, 4'b1000: dir = KNOB_UP;
      4'b0010, 4'b1011, 4'b1101, 4'b0100: dir = KNOB_DOWN;
      default:                            dir = KNOB_HOLD;
    endcase
    return dir;
  endfunction

  // phase increment per tick at the reference octave
  function automatic logic [PhaseW-1:0] base_step(input logic [NoteW-1:0] note);
    logic [PhaseW-1:0] step;
    case (note)
      4'd0:    step = 32'd51076002;
      4'd1:    step = 32'd54098238;
      4'd2:    step = 32'd57307049;
      4'd3:    step = 32'd60715768;
      4'd4:    step = 32'd64338225;
      4'd5:    step = 32'd68188717;
      4'd6:    step = 32'd72282135;
      4'd7:    step = 32'd76633902;
      4'd8:    step = 32'd81260097;
      4'd9:    step = 32'd86177490;
      4'd10:   step = 32'd91403586;
      4'd11:   step = 32'd96956624;
      default: step = '0;
    endcase
    return step;
  endfunction

endpackage

FILE: hw/rtl/kbsv_tone.sv
// phase step register, phase accumulator and sawtooth sample generation
module kbsv_tone import kbsv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tone_ctrl_t          ctrl_i,
  input  logic [7:0]          rx_type_i,
  input  logic [OctW-1:0]     rx_octave_i,
  input  logic [7:0]          rx_note_i,
  input  logic [VolW-1:0]     volume_i,
  output logic [7:0]          sample_o
);

  logic [PhaseW-1:0] step_q, step_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [PhaseW-1:0] base;
  logic [PhaseW-1:0] scaled;
  logic              note_ok;
  logic [VolW-1:0]   vol;
  logic [VolW-1:0]   shamt;
  logic [8:0]        biased;
  logic [8:0]        result;

  assign note_ok = (rx_note_i < {4'd0, NOTE_COUNT});
  assign base    = base_step(rx_note_i[NoteW-1:0]);

  always_comb begin
    if (rx_octave_i >= OCTAVE_BASE) begin
      scaled = base << (rx_octave_i - OCTAVE_BASE);
    end else begin
      scaled = base >> (OCTAVE_BASE - rx_octave_i);
    end
  end

  always_comb begin
    step_d = step_q;
    if (ctrl_i.note_we && note_ok) begin
      if (rx_type_i == RX_PRESSED) begin
        step_d = scaled;
      end else if (rx_type_i == RX_RELEASED) begin
        step_d = '0;
      end
    end
  end

  assign phase_d = phase_q + step_q;

  // floor((u - 128) / 2^s) + 128 kept in nine bits
  assign vol     = (volume_i > VOL_MAX) ? VOL_MAX : volume_i;
  assign shamt   = VOL_MAX - vol;
  assign biased  = ({1'b0, phase_d[PhaseW-1 -: 8]} + 9'd128) >> shamt;
  assign result  = biased - (9'd256 >> shamt) + 9'd128;
  assign sample_o = result[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      phase_q <= '0;
    end else begin
      step_q <= step_d;
      if (ctrl_i.tick) begin
        phase_q <= phase_d;
      end
    end
  end

endmodule

FILE: hw/rtl/keyboard_synth_voice.sv
// keyboard synth voice top level: key scan, volume knob and sawtooth voice
//
//   channel | signals                          | payload
//   --------+----------------------------------+-------------------
//   in      | in_valid_i / in_ready_o          | in_data_i  (in_item_t)
//   out     | out_valid_o / out_ready_i        | out_data_o (out_item_t)
//   cfg     | cfg_we_i                         | cfg_wdata_i (octave)
//
// one input transaction per cycle while in_ready_o is high; a scan with n changed keys
// holds the pending register for n output transfers, one key event each, lowest first.
// a tick gives one sample via the pending and output registers; note and quiet scans
// give none. rst_ni low async-resets all but pend_q and out_q; octave resets to 4.
// out stalls fill the output register then the pending register, then in_ready_o drops.
module keyboard_synth_voice import kbsv_pkg::*; #(
  parameter int unsigned NumKeys = NumKeysDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_data_o,
  input  logic            cfg_we_i,
  input  logic [OctW-1:0] cfg_wdata_i
);

  typedef struct packed {
    logic               is_sample;
    logic [NumKeys-1:0] mask;
    logic [NumKeys-1:0] keys;
    logic [OctW-1:0]    octave;
    logic [VolW-1:0]    volume;
    logic [7:0]         sample;
  } pend_t;

  logic [OctW-1:0]    octave_q;
  logic [NumKeys-1:0] prev_keys_q;
  logic [1:0]         prev_knob_q;
  logic               first_scan_q;
  logic [VolW-1:0]    volume_q, volume_d;

  logic               pend_valid_q, pend_valid_d;
  pend_t              pend_q, pend_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic               accept;
  logic               scan_acc;
  logic               tick_acc;
  logic [1:0]         knob_cur;
  logic [NumKeys-1:0] keys;
  logic [NumKeys-1:0] changed;
  knob_dir_e          dir;
  logic [7:0]         tone_sample;
  tone_ctrl_t         tone_ctrl;

  logic               out_load;
  logic               pend_last;
  logic [NumKeys-1:0] mask_rest;
  logic [NumKeys-1:0] low_bit;
  logic [NoteW-1:0]   low_idx;

  assign accept   = in_valid_i && in_ready_o;
  assign scan_acc = accept && (in_data_i.kind == KIND_SCAN);
  assign tick_acc = accept && (in_data_i.kind == KIND_TICK);

  // knob pins are active low
  assign knob_cur = ~in_data_i.key_bits[13:12];
  assign keys     = in_data_i.key_bits[NumKeys-1:0];
  assign changed  = keys ^ prev_keys_q;
  assign dir      = knob_dir({prev_knob_q, knob_cur});

  always_comb begin
    volume_d = volume_q;
    if (scan_acc && !first_scan_q) begin
      if (dir == KNOB_UP && volume_q < VOL_MAX) begin
        volume_d = volume_q + 1'b1;
      end else if (dir == KNOB_DOWN && volume_q != '0) begin
        volume_d = volume_q - 1'b1;
      end
    end
  end

  assign tone_ctrl.note_we = accept && (in_data_i.kind == KIND_NOTE);
  assign tone_ctrl.tick    = tick_acc;

  kbsv_tone u_tone (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (tone_ctrl),
    .rx_type_i   (in_data_i.rx_type),
    .rx_octave_i (in_data_i.rx_octave),
    .rx_note_i   (in_data_i.rx_note),
    .volume_i    (volume_q),
    .sample_o    (tone_sample)
  );

  // pending register drains one key event per output slot
  assign mask_rest = pend_q.mask & (pend_q.mask - 1'b1);
  assign low_bit   = pend_q.mask & ~(pend_q.mask - 1'b1);
  assign pend_last = pend_q.is_sample || (mask_rest == '0);
  assign out_load  = pend_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pend_valid_q || (out_load && pend_last);

  always_comb begin
    low_idx = '0;
    for (int k = NumKeys - 1; k >= 0; k--) begin
      if (pend_q.mask[k]) begin
        low_idx = NoteW'(k);
      end
    end
  end

  always_comb begin
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q && !(out_load && pend_last);
    if (out_load && !pend_last) begin
      pend_d.mask = mask_rest;
    end
    if ((scan_acc && changed != '0) || tick_acc) begin
      pend_valid_d     = 1'b1;
      pend_d.is_sample = tick_acc;
      pend_d.mask      = changed;
      pend_d.keys      = keys;
      pend_d.octave    = octave_q;
      pend_d.volume    = tick_acc ? volume_q : volume_d;
      pend_d.sample    = tone_sample;
    end
  end

  always_comb begin
    out_valid_d = out_load || (out_valid_q && !out_ready_i);
    out_d       = out_q;
    if (out_load) begin
      out_d.volume = pend_q.volume;
      if (pend_q.is_sample) begin
        out_d.out_kind      = OUT_SAMPLE;
        out_d.event_pressed = 1'b0;
        out_d.event_octave  = '0;
        out_d.event_note    = '0;
        out_d.last          = 1'b1;
        out_d.sample        = pend_q.sample;
      end else begin
        out_d.out_kind      = OUT_EVENT;
        out_d.event_pressed = ~|(pend_q.keys & low_bit);
        out_d.event_octave  = pend_q.octave;
        out_d.event_note    = low_idx;
        out_d.last          = pend_last;
        out_d.sample        = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_q     <= OCTAVE_BASE;
      prev_keys_q  <= '0;
      prev_knob_q  <= '0;
      first_scan_q <= 1'b1;
      volume_q     <= VOL_MAX;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        octave_q <= cfg_wdata_i;
      end
      if (scan_acc) begin
        prev_keys_q  <= keys;
        prev_knob_q  <= knob_cur;
        first_scan_q <= 1'b0;
      end
      volume_q     <= volume_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_vol_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    volume_q <= VOL_MAX)
    else $error("volume above maximum");

  a_pend_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (pend_q.is_sample || pend_q.mask != '0))
    else $error("pending entry without work");

  a_sample_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.out_kind == OUT_SAMPLE) |-> out_data_o.last)
    else $error("sample transaction not flagged last");

  a_first_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(first_scan_q) |-> $past(scan_acc))
    else $error("first scan flag cleared without a scan");

endmodule
